// ----- rtl/core/weighted_share_muldiv_assert.svh -----
// assertion macros shared by the rtl files
`ifndef WEIGHTED_SHARE_MULDIV_ASSERT_SVH
`define WEIGHTED_SHARE_MULDIV_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define WSM_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define WSM_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/wsm_pkg.sv -----
package wsm_pkg;

    localparam int FIELD_MSB      = 63;
    localparam int DATA_WIDTH_DEF = FIELD_MSB + 1;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_DIV_ZERO = 2'd1;
    localparam logic [1:0] ST_OVERFLOW = 2'd2;

    typedef struct packed {
        logic [FIELD_MSB:0] value;
        logic [FIELD_MSB:0] weight_numerator;
        logic [FIELD_MSB:0] weight_denominator;
    } req_t;

    typedef struct packed {
        logic [FIELD_MSB:0] share;
        logic [1:0]         status;
    } rsp_t;

    typedef enum logic [1:0] {
        KIND_DIV  = 2'd0,
        KIND_ZERO = 2'd1,
        KIND_DIV0 = 2'd2,
        KIND_OVF  = 2'd3
    } kind_t;

    typedef struct packed {
        logic  valid;
        kind_t kind;
    } ctl_t;

endpackage

// ----- rtl/core/wsm_front.sv -----
`include "weighted_share_muldiv_assert.svh"

module wsm_front #(
    parameter int DATA_WIDTH = wsm_pkg::DATA_WIDTH_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  en,
    input  logic                  req_valid,
    input  wsm_pkg::req_t         req,
    output wsm_pkg::ctl_t         ctl,
    output logic [DATA_WIDTH-1:0] p_hi,
    output logic [DATA_WIDTH-1:0] p_lo,
    output logic [DATA_WIDTH-1:0] den
);
    import wsm_pkg::*;

    localparam int W  = DATA_WIDTH;
    localparam int HW = (W + 1) / 2;
    localparam int UW = W - HW;
    localparam int PW = 2 * W;

    logic [W-1:0] a;
    logic [W-1:0] b;

    // partial products
    logic            s1_valid_reg;
    logic [2*HW-1:0] pp_ll_reg;
    logic [W-1:0]    pp_lh_reg;
    logic [W-1:0]    pp_hl_reg;
    logic [2*UW-1:0] pp_hh_reg;
    logic [W-1:0]    d1_reg;

    // full product
    logic            s2_valid_reg;
    logic [PW-1:0]   prod_next;
    logic [PW-1:0]   prod_reg;
    logic [W-1:0]    d2_reg;

    // classified operands
    ctl_t            ctl_reg;
    ctl_t            ctl_next;
    logic [PW-1:0]   prod3_reg;
    logic [W-1:0]    d3_reg;

    assign a = req.value[W-1:0];
    assign b = req.weight_numerator[W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            ctl_reg      <= '0;
        end
        else if (en)
        begin
            s1_valid_reg <= req_valid;
            s2_valid_reg <= s1_valid_reg;
            ctl_reg      <= ctl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pp_ll_reg <= (2 * HW)'(a[HW-1:0]) * (2 * HW)'(b[HW-1:0]);
            pp_lh_reg <= W'(a[HW-1:0]) * W'(b[W-1:HW]);
            pp_hl_reg <= W'(a[W-1:HW]) * W'(b[HW-1:0]);
            pp_hh_reg <= (2 * UW)'(a[W-1:HW]) * (2 * UW)'(b[W-1:HW]);
            d1_reg    <= req.weight_denominator[W-1:0];
            prod_reg  <= prod_next;
            d2_reg    <= d1_reg;
            prod3_reg <= prod_reg;
            d3_reg    <= d2_reg;
        end
    end

    assign prod_next = PW'(pp_ll_reg)
                     + (PW'(pp_lh_reg) << HW)
                     + (PW'(pp_hl_reg) << HW)
                     + (PW'(pp_hh_reg) << (2 * HW));

    always_comb
    begin
        ctl_next.valid = s2_valid_reg;
        if (prod_reg == '0)
        begin
            ctl_next.kind = KIND_ZERO;
        end
        else if (d2_reg == '0)
        begin
            ctl_next.kind = KIND_DIV0;
        end
        else if (prod_reg[PW-1:W] >= d2_reg)
        begin
            ctl_next.kind = KIND_OVF;
        end
        else
        begin
            ctl_next.kind = KIND_DIV;
        end
    end

    assign ctl  = ctl_reg;
    assign p_hi = prod3_reg[PW-1:W];
    assign p_lo = prod3_reg[W-1:0];
    assign den  = d3_reg;

    `WSM_ASSERT_IMP(a_div_fits, ctl_reg.valid && ctl_reg.kind == KIND_DIV,
        prod3_reg[PW-1:W] < d3_reg, "divide item with high word not below divisor")

endmodule

// ----- rtl/core/wsm_div_step.sv -----
module wsm_div_step #(
    parameter int DATA_WIDTH = wsm_pkg::DATA_WIDTH_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  en,
    input  wsm_pkg::ctl_t         src_ctl,
    input  logic [DATA_WIDTH-1:0] src_rem,
    input  logic [DATA_WIDTH-1:0] src_acc,
    input  logic [DATA_WIDTH-1:0] src_den,
    output wsm_pkg::ctl_t         ctl,
    output logic [DATA_WIDTH-1:0] rem,
    output logic [DATA_WIDTH-1:0] acc,
    output logic [DATA_WIDTH-1:0] den
);
    import wsm_pkg::*;

    localparam int W = DATA_WIDTH;

    logic [W:0]   shifted;
    logic [W:0]   diff;
    logic         take;
    logic [W-1:0] rem_next;
    logic [W-1:0] acc_next;

    ctl_t         ctl_reg;
    logic [W-1:0] rem_reg;
    logic [W-1:0] acc_reg;
    logic [W-1:0] den_reg;

    // acc holds the dividend bits still to come in its upper part and quotient bits below
    assign shifted  = {src_rem, src_acc[W-1]};
    assign diff     = shifted - {1'b0, src_den};
    assign take     = shifted >= {1'b0, src_den};
    assign rem_next = take ? diff[W-1:0] : shifted[W-1:0];
    assign acc_next = {src_acc[W-2:0], take};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else if (en)
        begin
            ctl_reg <= src_ctl;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg <= rem_next;
            acc_reg <= acc_next;
            den_reg <= src_den;
        end
    end

    assign ctl = ctl_reg;
    assign rem = rem_reg;
    assign acc = acc_reg;
    assign den = den_reg;

endmodule

// ----- rtl/core/wsm_out_buf.sv -----
module wsm_out_buf (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  wsm_pkg::rsp_t item,
    output logic          space,
    output logic          rsp_valid,
    input  logic          rsp_ready,
    output wsm_pkg::rsp_t rsp
);
    import wsm_pkg::*;

    localparam logic [1:0] CNT_EMPTY = 2'd0;
    localparam logic [1:0] CNT_ONE   = 2'd1;
    localparam logic [1:0] CNT_FULL  = 2'd2;

    logic [1:0] count_reg;
    logic [1:0] count_next;
    rsp_t       head_reg;
    rsp_t       skid_reg;
    logic       wr;
    logic       rd;

    assign space = count_reg != CNT_FULL;
    assign wr    = push && space;
    assign rd    = rsp_valid && rsp_ready;

    always_comb
    begin
        count_next = count_reg;
        if (wr && !rd)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (rd && !wr)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= CNT_EMPTY;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd && count_reg == CNT_FULL)
        begin
            head_reg <= skid_reg;
        end
        else if (wr && (count_reg == CNT_EMPTY || rd))
        begin
            head_reg <= item;
        end
        if (wr && count_reg == CNT_ONE && !rd)
        begin
            skid_reg <= item;
        end
    end

    assign rsp_valid = count_reg != CNT_EMPTY;
    assign rsp       = head_reg;

endmodule

// ----- rtl/core/weighted_share_muldiv.sv -----
// channel  direction  handshake              payload
// req      in         req_valid / req_ready  req.value, req.weight_numerator,
//                                            req.weight_denominator
// rsp      out        rsp_valid / rsp_ready  rsp.share, rsp.status
//
// one transfer accepted per cycle while the output buffer has space (req_ready);
// three multiply and classify stages, then one restoring divide step per stage
// rst_n clears all valid bits and the output buffer; no clearing pass
// a stalled rsp freezes the whole pipe once the two-entry output buffer is full
`include "weighted_share_muldiv_assert.svh"

module weighted_share_muldiv #(
    parameter int DATA_WIDTH = wsm_pkg::DATA_WIDTH_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_ready,
    input  wsm_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_ready,
    output wsm_pkg::rsp_t rsp
);
    import wsm_pkg::*;

    localparam int W = DATA_WIDTH;

    logic         en;
    ctl_t         ctl_c [W+1];
    logic [W-1:0] rem_c [W+1];
    logic [W-1:0] acc_c [W+1];
    logic [W-1:0] den_c [W+1];
    rsp_t         result;

    assign req_ready = en;

    wsm_front #(
        .DATA_WIDTH (W)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .req_valid (req_valid),
        .req       (req),
        .ctl       (ctl_c[0]),
        .p_hi      (rem_c[0]),
        .p_lo      (acc_c[0]),
        .den       (den_c[0])
    );

    for (genvar i = 0; i < W; i++)
    begin : g_div
        wsm_div_step #(
            .DATA_WIDTH (W)
        ) u_step (
            .clk     (clk),
            .rst_n   (rst_n),
            .en      (en),
            .src_ctl (ctl_c[i]),
            .src_rem (rem_c[i]),
            .src_acc (acc_c[i]),
            .src_den (den_c[i]),
            .ctl     (ctl_c[i+1]),
            .rem     (rem_c[i+1]),
            .acc     (acc_c[i+1]),
            .den     (den_c[i+1])
        );
    end

    always_comb
    begin
        case (ctl_c[W].kind)
            KIND_DIV:
            begin
                result.share  = (FIELD_MSB + 1)'(acc_c[W]);
                result.status = ST_OK;
            end
            KIND_ZERO:
            begin
                result.share  = '0;
                result.status = ST_OK;
            end
            KIND_DIV0:
            begin
                result.share  = '0;
                result.status = ST_DIV_ZERO;
            end
            KIND_OVF:
            begin
                result.share  = (FIELD_MSB + 1)'({W{1'b1}});
                result.status = ST_OVERFLOW;
            end
            default:
            begin
                result.share  = '0;
                result.status = ST_OK;
            end
        endcase
    end

    wsm_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (ctl_c[W].valid),
        .item      (result),
        .space     (en),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    `WSM_ASSERT_NXT(a_stall_freezes, !en && ctl_c[W].valid,
        ctl_c[W].valid && $stable(acc_c[W]), "pipe moved while output buffer full")
    `WSM_ASSERT_IMP(a_share_width, rsp_valid,
        (rsp.share >> W) == '0, "share wider than data width")
    `WSM_ASSERT_IMP(a_div0_zero, rsp_valid && rsp.status == ST_DIV_ZERO,
        rsp.share == '0, "zero divisor with nonzero share")

endmodule
